[rtl/core/tccs_pkg.sv]
package tccs_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CELL_W = 16;

   // fixed field widths of the request and response words
   localparam int KIND_W     = 2;
   localparam int BYTE_W     = 8;
   localparam int REQ_ADDR_W = 11;
   localparam int POS_W      = 11;

   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_RETURN  = 8'd13;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0700;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [BYTE_W-1:0] read_character;
      logic [BYTE_W-1:0] read_attribute;
   } result_type;

endpackage

[rtl/core/tccs_ram.sv]
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tccs_seq.sv]
module tccs_seq import tccs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [BYTE_W-1:0]     req_char_code,
   input  logic [BYTE_W-1:0]     req_attribute,
   input  logic [REQ_ADDR_W-1:0] req_cell_address,
   output logic                  busy,
   input  logic                  out_free,
   output logic                  done,
   output result_type            result,
   output ram_req_type           ram_req,
   input  logic [CELL_W-1:0]     ram_rd_data
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RDATA,
      ST_SCROLL,
      ST_FILL,
      ST_DONE
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] COPY_COUNT = ADDR_W'(CELL_COUNT - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W:0]   POS_LIMIT  = (ADDR_W+1)'(CELL_COUNT);
   localparam logic [COL_W:0]    COL_LIMIT  = (COL_W+1)'(COLUMNS);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [BYTE_W-1:0] rd_char_ff, rd_char_in;
   logic [BYTE_W-1:0] rd_attr_ff, rd_attr_in;

   logic [COL_W:0]                col_next;
   logic                          col_wrap;
   logic [ADDR_W:0]               pos_next;
   logic                          is_special;
   logic                          addr_ok;
   logic [ADDR_W+POS_W-1:0]       pos_wide;
   logic [ADDR_W+REQ_ADDR_W-1:0]  addr_wide;

   assign col_next   = {1'b0, col_ff} + (COL_W+1)'(1);
   assign col_wrap   = (col_next == COL_LIMIT);
   assign is_special = (req_char_code == CHAR_NEWLINE) || (req_char_code == CHAR_RETURN);
   assign addr_wide  = (ADDR_W+REQ_ADDR_W)'(req_cell_address);
   assign addr_ok    = (addr_wide < (ADDR_W+REQ_ADDR_W)'(CELL_COUNT));

   always_comb begin
      if (req_char_code == CHAR_NEWLINE) begin
         pos_next = {1'b0, pos_ff} - (ADDR_W+1)'(col_ff) + (ADDR_W+1)'(COLUMNS);
      end else if (req_char_code == CHAR_RETURN) begin
         pos_next = {1'b0, pos_ff} - (ADDR_W+1)'(col_ff);
      end else begin
         pos_next = {1'b0, pos_ff} + (ADDR_W+1)'(1);
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      col_in     = col_ff;
      pos_in     = pos_ff;
      wr_pend_in = wr_pend_ff;
      wr_addr_in = wr_addr_ff;
      rd_char_in = rd_char_ff;
      rd_attr_in = rd_attr_ff;
      ram_req    = '0;
      done       = 1'b0;

      unique case (state_ff)
         ST_INIT, ST_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = BLANK_CELL;
            if (idx_ff == LAST_CELL) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rd_char_in = '0;
               rd_attr_in = '0;
               state_in   = ST_DONE;
               unique case (req_kind)
                  KIND_PUT: begin
                     if (!is_special) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = pos_ff;
                        ram_req.wr_data = {req_attribute, req_char_code};
                     end
                     col_in = (is_special || col_wrap) ? '0 : col_next[COL_W-1:0];
                     if (pos_next == POS_LIMIT) begin
                        // past the bottom: park on the last row and move the store up
                        pos_in     = COPY_COUNT;
                        idx_in     = '0;
                        wr_pend_in = 1'b0;
                        state_in   = ST_SCROLL;
                     end else begin
                        pos_in = pos_next[ADDR_W-1:0];
                     end
                  end
                  KIND_CLEAR: begin
                     col_in   = '0;
                     pos_in   = '0;
                     idx_in   = '0;
                     state_in = ST_FILL;
                  end
                  KIND_READ: begin
                     if (addr_ok) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = ADDR_W'(req_cell_address);
                        state_in        = ST_RDATA;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RDATA: begin
            rd_char_in = ram_rd_data[BYTE_W-1:0];
            rd_attr_in = ram_rd_data[CELL_W-1:BYTE_W];
            state_in   = ST_DONE;
         end
         ST_SCROLL: begin
            // write back the word fetched last cycle one row higher
            if (wr_pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wr_addr_ff;
               ram_req.wr_data = ram_rd_data;
            end
            if (idx_ff < COPY_COUNT) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_ff + ROW_STEP;
               wr_addr_in      = idx_ff;
               wr_pend_in      = 1'b1;
               idx_in          = idx_ff + ADDR_W'(1);
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         idx_ff     <= '0;
         col_ff     <= '0;
         pos_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         col_ff     <= col_in;
         pos_ff     <= pos_in;
         wr_pend_ff <= wr_pend_in;
      end
      wr_addr_ff <= wr_addr_in;
      rd_char_ff <= rd_char_in;
      rd_attr_ff <= rd_attr_in;
   end

   assign pos_wide = (ADDR_W+POS_W)'(pos_ff);

   assign busy                   = (state_ff != ST_IDLE);
   assign result.cursor_position = pos_wide[POS_W-1:0];
   assign result.read_character  = rd_char_ff;
   assign result.read_attribute  = rd_attr_ff;

endmodule

[rtl/core/text_console_cursor_scroll.sv]
// Text console: a 80 x 25 row-major screen store of character/attribute cells held in one
// synchronous RAM (one write and one registered read per cycle), plus a cursor. After reset
// a clearing pass blanks all 2000 cells, one per cycle, and no request word is taken until
// it ends. A put of an ordinary byte, a newline or a carriage return goes from acceptance
// to the done state, a read of a cell in the store passes the RAM read state first (a read
// beyond the store does not), and done loads the response word once the output register
// is free; the sequencer is then idle again and may take the next request word. A put that
// runs past the bottom row scrolls: 1920 cells are copied one row up through the RAM port
// (one per cycle) and the last row is blanked. A clear walks the whole store.
// One request is in flight at a time; the response word is held in an output register, so
// the next request is taken while the previous response still waits.
module text_console_cursor_scroll import tccs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [BYTE_W-1:0]     req_char_code,
   input  logic [BYTE_W-1:0]     req_attribute,
   input  logic [REQ_ADDR_W-1:0] req_cell_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_W-1:0]      rsp_cursor_position,
   output logic [BYTE_W-1:0]     rsp_read_character,
   output logic [BYTE_W-1:0]     rsp_read_attribute
);

   ram_req_type       ram_req;
   logic [CELL_W-1:0] ram_rd_data;
   result_type        result;
   logic              busy;
   logic              done;
   logic              out_free;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   tccs_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_kind         (req_kind),
      .req_char_code    (req_char_code),
      .req_attribute    (req_attribute),
      .req_cell_address (req_cell_address),
      .busy             (busy),
      .out_free         (out_free),
      .done             (done),
      .result           (result),
      .ram_req          (ram_req),
      .ram_rd_data      (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall           = busy;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_data_ff.cursor_position;
   assign rsp_read_character  = rsp_data_ff.read_character;
   assign rsp_read_attribute  = rsp_data_ff.read_attribute;

endmodule

[bench/tccs_screen_checker.sv]
`timescale 1ns / 100ps

module tccs_screen_checker import tccs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [BYTE_W-1:0]     req_char_code,
   input  logic [BYTE_W-1:0]     req_attribute,
   input  logic [REQ_ADDR_W-1:0] req_cell_address,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [POS_W-1:0]      rsp_cursor_position,
   input  logic [BYTE_W-1:0]     rsp_read_character,
   input  logic [BYTE_W-1:0]     rsp_read_attribute,
   output int                    error_count,
   output int                    pending_words
);

   localparam int ROW_W     = $clog2(ROWS + 1);
   localparam int CUR_COL_W = $clog2(COLUMNS + 1);

   logic [CELL_W-1:0]    screen [CELL_COUNT];
   logic [CUR_COL_W-1:0] cursor_col;
   logic [ROW_W-1:0]     cursor_row;
   result_type           awaited_words [$];
   result_type           oldest_word;

   initial begin
      error_count   = 0;
      pending_words = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic blank_screen();
      for (int i = 0; i < CELL_COUNT; i++)
         screen[i] = BLANK_CELL;
      cursor_col = '0;
      cursor_row = '0;
   endtask

   // work out the response word of one request and queue it
   task automatic predict_console_word(input logic [KIND_W-1:0]     kind,
                                       input logic [BYTE_W-1:0]     code,
                                       input logic [BYTE_W-1:0]     attr,
                                       input logic [REQ_ADDR_W-1:0] addr);
      result_type word;
      int         pos;
      word = '0;
      case (kind)
         KIND_PUT: begin
            if (code == CHAR_NEWLINE) begin
               cursor_col = '0;
               cursor_row++;
            end else if (code == CHAR_RETURN) begin
               cursor_col = '0;
            end else begin
               screen[int'(cursor_row) * COLUMNS + int'(cursor_col)] = {attr, code};
               cursor_col++;
            end
            if (cursor_col >= COLUMNS) begin
               cursor_col = '0;
               cursor_row++;
            end
            // past the bottom: move every line up one and blank the last
            if (cursor_row >= ROWS) begin
               for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                  screen[i] = screen[i + COLUMNS];
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  screen[i] = BLANK_CELL;
               cursor_row = ROW_W'(ROWS - 1);
            end
         end
         KIND_CLEAR: begin
            blank_screen();
         end
         KIND_READ: begin
            if (addr < CELL_COUNT)
               {word.read_attribute, word.read_character} = screen[addr];
         end
         default: begin
         end
      endcase
      pos = int'(cursor_row) * COLUMNS + int'(cursor_col);
      word.cursor_position = pos[POS_W-1:0];
      awaited_words.push_back(word);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         blank_screen();
         awaited_words.delete();
      end else begin
         // retire the response before queueing a new request
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               report_mismatch($sformatf("response word with none awaited (position %0d)",
                                         rsp_cursor_position));
            end else begin
               oldest_word = awaited_words.pop_front();
               if (rsp_cursor_position !== oldest_word.cursor_position)
                  report_mismatch($sformatf("cursor_position %0d, want %0d",
                                            rsp_cursor_position, oldest_word.cursor_position));
               if (rsp_read_character !== oldest_word.read_character)
                  report_mismatch($sformatf("read_character %h, want %h",
                                            rsp_read_character, oldest_word.read_character));
               if (rsp_read_attribute !== oldest_word.read_attribute)
                  report_mismatch($sformatf("read_attribute %h, want %h",
                                            rsp_read_attribute, oldest_word.read_attribute));
            end
         end
         if (req_valid && !req_stall)
            predict_console_word(req_kind, req_char_code, req_attribute, req_cell_address);
      end
      pending_words = awaited_words.size();
   end

endmodule

[bench/text_console_cursor_scroll_tb.sv]
`timescale 1ns / 100ps

module text_console_cursor_scroll_tb;
   import tccs_pkg::*;

   localparam int ITEM_TARGET  = 1650;
   localparam int CYCLE_LIMIT  = 16_000_000;
   localparam int DRAIN_CYCLES = 2100;

   // the block answers this kind without touching the store or the cursor; it has no name in the package
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind         = '0;
   logic [BYTE_W-1:0]     req_char_code    = '0;
   logic [BYTE_W-1:0]     req_attribute    = '0;
   logic [REQ_ADDR_W-1:0] req_cell_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [POS_W-1:0]      rsp_cursor_position;
   logic [BYTE_W-1:0]     rsp_read_character;
   logic [BYTE_W-1:0]     rsp_read_attribute;

   int send_idle_pct = 38;
   int rsp_stall_pct = 49;
   int sent_words    = 0;
   int cycle_count   = 0;
   int error_count;
   int pending_words;

   text_console_cursor_scroll DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_attribute       (req_attribute),
      .req_cell_address    (req_cell_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_read_character  (rsp_read_character),
      .rsp_read_attribute  (rsp_read_attribute)
   );

   tccs_screen_checker screen_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_attribute       (req_attribute),
      .req_cell_address    (req_cell_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_read_character  (rsp_read_character),
      .rsp_read_attribute  (rsp_read_attribute),
      .error_count         (error_count),
      .pending_words       (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   // bias reads towards the lower rows, where scrolling moves text
   function automatic logic [REQ_ADDR_W-1:0] random_cell_address();
      if ($urandom_range(2) == 0)
         return REQ_ADDR_W'($urandom_range(1840, 2047));
      return REQ_ADDR_W'($urandom);
   endfunction

   // offer one word from a falling edge and return at the falling edge after acceptance
   task automatic send_word(input logic [KIND_W-1:0]     kind,
                            input logic [BYTE_W-1:0]     code,
                            input logic [BYTE_W-1:0]     attr,
                            input logic [REQ_ADDR_W-1:0] addr);
      if (sent_words < ITEM_TARGET / 3) begin
         send_idle_pct = 38;
         rsp_stall_pct = 49;
      end else if (sent_words < 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 49;
         rsp_stall_pct = 38;
      end else begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_char_code    <= code;
      req_attribute    <= attr;
      req_cell_address <= addr;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      if (kind != KIND_UNUSED)
         sent_words++;
   endtask

   initial begin
      int pick;
      int line_len;
      int burst;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // blank store, top and bottom cells, reads beyond the store; puts, CR/LF, unused kinds, clear
      send_word(KIND_READ, 8'h00, 8'h00, 11'd0);
      send_word(KIND_READ, 8'hFF, 8'hFF, 11'd1999);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd2000);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd2047);
      send_word(KIND_PUT, 8'h41, 8'h1E, 11'd0);
      send_word(KIND_PUT, 8'h00, 8'h00, 11'd2047);
      send_word(KIND_PUT, 8'hFF, 8'hFF, 11'd0);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd0);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd1);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd2);
      send_word(KIND_PUT, CHAR_RETURN, 8'h55, 11'd0);
      send_word(KIND_PUT, 8'h42, 8'h70, 11'd0);
      send_word(KIND_PUT, CHAR_NEWLINE, 8'hAA, 11'd0);
      send_word(KIND_UNUSED, CHAR_NEWLINE, 8'h0F, 11'd5);
      send_word(KIND_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
      send_word(KIND_PUT, 8'h7E, 8'h80, 11'd0);
      send_word(KIND_PUT, CHAR_RETURN, 8'h00, 11'd0);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd0);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd80);
      send_word(KIND_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd0);
      send_word(KIND_READ, 8'h00, 8'h00, 11'd80);

      while (sent_words < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            // a line of text, now and then long enough to wrap
            line_len = ($urandom_range(4) == 0) ? $urandom_range(70, 170)
                                                : $urandom_range(0, 12);
            for (int n = 0; n < line_len; n++) begin
               if ($urandom_range(99) < 15)
                  send_word(KIND_READ, BYTE_W'($urandom), BYTE_W'($urandom),
                            random_cell_address());
               send_word(KIND_PUT, BYTE_W'($urandom), BYTE_W'($urandom),
                         REQ_ADDR_W'($urandom));
            end
            send_word(KIND_PUT, ($urandom_range(99) < 85) ? CHAR_NEWLINE : CHAR_RETURN,
                      BYTE_W'($urandom), REQ_ADDR_W'($urandom));
         end else if (pick < 90) begin
            burst = $urandom_range(1, 8);
            repeat (burst)
               send_word(KIND_READ, BYTE_W'($urandom), BYTE_W'($urandom),
                         random_cell_address());
         end else if (pick < 94) begin
            burst = $urandom_range(1, 4);
            repeat (burst)
               send_word(KIND_PUT, CHAR_NEWLINE, BYTE_W'($urandom), REQ_ADDR_W'($urandom));
         end else if (pick < 98) begin
            send_word(KIND_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                      REQ_ADDR_W'($urandom));
         end else begin
            send_word(KIND_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom),
                      REQ_ADDR_W'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (pending_words != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/tccs_pkg.sv
rtl/core/tccs_ram.sv
rtl/core/tccs_seq.sv
rtl/core/text_console_cursor_scroll.sv
bench/tccs_screen_checker.sv
bench/text_console_cursor_scroll_tb.sv
